[rtl/ctf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg
// Types and constants for the complementary tilt filter core.
// ----------------------------------------------------------------------------
package ctf_pkg;

    localparam logic [31:0] GAIN_Q30   = 32'd1768195363;
    localparam logic [31:0] PI_Q28     = 32'd843314857;
    localparam logic [31:0] DEG256_Q16 = 32'd961263669;
    localparam int          DEG_LIMIT  = 46080;
    localparam logic [16:0] COEFF_ONE  = 17'd65536;

    localparam logic [0:0]  REG_BLEND  = 1'b0;
    localparam logic [0:0]  REG_GAIN   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PASS1,
        ST_PREP2,
        ST_PASS2,
        ST_GYRO,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_SAT,
        ST_DEG,
        ST_NEXT,
        ST_OUT
    } state_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/complementary_tilt_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_tilt_filter_core
// Pitch and roll complementary filter with a shared CORDIC vectoring unit.
// ----------------------------------------------------------------------------
// One item is one raw IMU sample; one result item carries pitch and roll in
// 1/256 degree. The block takes one item at a time: in_stall is high from
// acceptance until the cycle after the result has been taken. Each axis runs
// two CORDIC vectoring passes of CORDIC_STEPS iterations on one shared
// add/shift unit, then gyro integration, blend, saturation and degree
// conversion on one shared multiplier. An axis whose tilt numerator is zero
// skips both passes and the ST_PREP2 gain step between them. While out_stall
// is high the result is held in ST_OUT.
// Configuration writes are taken at any cycle but must only be issued idle.
module complementary_tilt_filter_core
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] pitch_deg,
    output logic signed [16:0] roll_deg
);

    localparam int SW = $clog2(CORDIC_STEPS);

    // Configuration
    logic [16:0] blend_coeff_reg;
    logic [31:0] gain_reg;

    // Filter state (Q4.28)
    logic signed [31:0] pitch_reg, roll_reg;

    // Latched sample
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;

    state_t state_reg, state_next;
    logic   axis_reg;   // 0: pitch, 1: roll
    logic [SW-1:0] step_reg;

    // CORDIC working registers; |x| grows to about 2^31 from 16+14 bit inputs
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [35:0] cz_reg;
    // Shared wide scratch for gyro/blend/degree work
    logic signed [63:0] acc_reg;
    logic signed [31:0] tilt_reg;
    logic signed [16:0] pdeg_reg, rdeg_reg;

    logic signed [15:0] a_sel, b_sel, c_sel, g_sel;
    logic signed [31:0] ang_sel;
    assign a_sel   = axis_reg ? ay_reg : ax_reg;
    assign b_sel   = axis_reg ? ax_reg : ay_reg;
    assign c_sel   = az_reg;
    assign g_sel   = axis_reg ? gx_reg : gy_reg;
    assign ang_sel = axis_reg ? roll_reg : pitch_reg;

    // Shared CORDIC micro-rotation; >>> is a floor shift on signed values
    logic signed [35:0] dx, dy;
    logic signed [35:0] atan_ext;
    logic               last_step;
    assign dx        = cy_reg >>> step_reg;
    assign dy        = cx_reg >>> step_reg;
    assign atan_ext  = 36'(signed'({1'b0, atan_q30(5'(step_reg))}));
    assign last_step = (step_reg == SW'(CORDIC_STEPS - 1));

    logic [16:0] coeff_eff;
    assign coeff_eff = (blend_coeff_reg > COEFF_ONE) ? COEFF_ONE : blend_coeff_reg;

    // Shared multiplier operands; the gyro-integrated angle can reach
    // about 2^35 at full gain, so operand a is 38 bits
    logic signed [37:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [71:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [37:0] blend_g;
    logic signed [63:0] blend_round;
    logic signed [47:0] sat_v;
    logic signed [31:0] ang_new;
    logic signed [63:0] deg_v;
    logic signed [16:0] deg_clamp;

    assign blend_round = acc_reg + 64'sd32768;
    assign sat_v       = 48'(blend_round >>> 16);
    assign ang_new     = (sat_v > 48'(signed'({1'b0, PI_Q28})))  ? signed'(PI_Q28) :
                         (sat_v < -48'(signed'({1'b0, PI_Q28}))) ? -signed'(PI_Q28) :
                         32'(sat_v);
    assign deg_v       = (acc_reg + (64'sd1 <<< 43)) >>> 44;
    assign deg_clamp   = (deg_v > 64'(DEG_LIMIT))  ? 17'(DEG_LIMIT)  :
                         (deg_v < -64'(DEG_LIMIT)) ? -17'(DEG_LIMIT) : 17'(deg_v);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        blend_g = '0;
        unique case (state_reg)
            ST_PREP2:
            begin
                mul_a = 38'(a_sel);
                mul_b = 34'(signed'({1'b0, GAIN_Q30}));
            end
            ST_GYRO:
            begin
                mul_a = -38'(g_sel);
                mul_b = 34'(signed'({1'b0, gain_reg}));
            end
            ST_BLEND_A:
            begin
                blend_g = acc_reg[37:0];
                mul_a   = blend_g;
                mul_b   = 34'(signed'({1'b0, coeff_eff}));
            end
            ST_BLEND_B:
            begin
                mul_a = 38'(signed'({1'b0, COEFF_ONE - coeff_eff}));
                mul_b = 34'(tilt_reg);
            end
            ST_DEG:
            begin
                mul_a = 38'(ang_sel);
                mul_b = 34'(signed'({1'b0, DEG256_Q16}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_LOAD;
            ST_LOAD:    state_next = (a_sel == 16'sd0) ? ST_GYRO : ST_PASS1;
            ST_PASS1:   if (last_step) state_next = ST_PREP2;
            ST_PREP2:   state_next = ST_PASS2;
            ST_PASS2:   if (last_step) state_next = ST_GYRO;
            ST_GYRO:    state_next = ST_BLEND_A;
            ST_BLEND_A: state_next = ST_BLEND_B;
            ST_BLEND_B: state_next = ST_SAT;
            ST_SAT:     state_next = ST_DEG;
            ST_DEG:     state_next = ST_NEXT;
            ST_NEXT:    state_next = axis_reg ? ST_OUT : ST_LOAD;
            ST_OUT:     if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            blend_coeff_reg <= 17'd64225;
            gain_reg        <= '0;
            pitch_reg       <= '0;
            roll_reg        <= '0;
            axis_reg        <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLEND: blend_coeff_reg <= cfg_data[16:0];
                    REG_GAIN:  gain_reg        <= cfg_data;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:  axis_reg <= 1'b0;
                ST_LOAD:  step_reg <= '0;
                ST_PASS1, ST_PASS2: step_reg <= last_step ? '0 : step_reg + SW'(1);
                ST_SAT:
                begin
                    if (axis_reg) roll_reg  <= ang_new;
                    else          pitch_reg <= ang_new;
                end
                ST_NEXT:  axis_reg <= 1'b1;
                default:  ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ax_reg <= accel_x;
                    ay_reg <= accel_y;
                    az_reg <= accel_z;
                    gx_reg <= gyro_x;
                    gy_reg <= gyro_y;
                end
            end
            ST_LOAD:
            begin
                cx_reg   <= 36'(b_sel < 0 ? -32'(b_sel) : 32'(b_sel)) <<< 14;
                cy_reg   <= 36'(c_sel < 0 ? -32'(c_sel) : 32'(c_sel)) <<< 14;
                cz_reg   <= '0;
                tilt_reg <= '0;
            end
            ST_PASS1, ST_PASS2:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + atan_ext;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - atan_ext;
                end
                if (state_reg == ST_PASS2 && last_step)
                    tilt_reg <= 32'((((cy_reg >= 0) ? cz_reg + atan_ext : cz_reg - atan_ext)
                                     + 36'sd2) >>> 2);
            end
            ST_PREP2:
            begin
                cy_reg <= 36'(mul_p >>> 16);
                cz_reg <= '0;
            end
            ST_GYRO:    acc_reg <= 64'(ang_sel) + 64'((mul_p + 72'sd2048) >>> 12);
            ST_BLEND_A: acc_reg <= 64'(mul_p);
            ST_BLEND_B: acc_reg <= acc_reg + 64'(mul_p);
            ST_DEG:     acc_reg <= 64'(mul_p);
            ST_NEXT:
            begin
                if (axis_reg) rdeg_reg <= deg_clamp;
                else          pdeg_reg <= deg_clamp;
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign pitch_deg = pdeg_reg;
    assign roll_deg  = rdeg_reg;

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_reg <= signed'(PI_Q28)) && (pitch_reg >= -signed'(PI_Q28)))
        else $error("pitch out of range");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < SW'(CORDIC_STEPS)) else $error("step overrun");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pitch_deg) && $stable(roll_deg))
        else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept while result pending");

endmodule
